// File: rtl/group_reversal_reorder_macros.svh
// Assertion macros used by grr_checker, the port-level checker of the group reversal block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GROUP_REVERSAL_REORDER_MACROS_SVH
`define GROUP_REVERSAL_REORDER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GRR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("group reversal assertion failed");

// Next-cycle implication, disabled while reset is high.
`define GRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("group reversal assertion failed");

// Next-cycle implication that is also checked during reset.
`define GRR_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("group reversal assertion failed");

`endif

// File: rtl/grr_pkg.sv
// Package of the group reversal block: sizes, descriptor types and helpers.
// Used by every RTL file of the block but grr_ram; it depends on nothing else.
package grr_pkg;

  localparam int MAX_GROUP  = 16;
  localparam int DATA_W     = 32;
  localparam int GS_W       = 5;
  localparam int IDX_W      = $clog2(MAX_GROUP);
  localparam int CNT_W      = $clog2(MAX_GROUP + 1);
  localparam int NUM_BANKS  = 2;
  localparam int BANK_W     = $clog2(NUM_BANKS);
  localparam int ADDR_W     = BANK_W + IDX_W;
  localparam int RAM_DEPTH  = NUM_BANKS * MAX_GROUP;
  localparam int Q_PTR_W    = BANK_W;
  localparam int BAL_W      = $clog2(RAM_DEPTH + 4) + 1;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [CNT_W-1:0]  count;
    logic              rev;
    logic              last;
  } desc_t;

  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } release_t;

  typedef struct packed {
    logic                     en;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] data;
  } ram_wr_t;

  function automatic logic [CNT_W-1:0] eff_size(input logic [GS_W-1:0] gs);
    logic [CNT_W-1:0] k;
    if (gs == '0) begin
      k = CNT_W'(1);
    end else if (int'(gs) > MAX_GROUP) begin
      k = CNT_W'(MAX_GROUP);
    end else begin
      k = CNT_W'(gs);
    end
    return k;
  endfunction

endpackage

// File: rtl/grr_in_if.sv
// Input channel of the group reversal block: valid, ready and one value with its end flag.
// Depends on grr_pkg for the data width.
interface grr_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [grr_pkg::DATA_W-1:0] value_in;
  logic                             end_of_sequence;

  modport source (output valid, value_in, end_of_sequence, input ready);
  modport sink (input valid, value_in, end_of_sequence, output ready);
endinterface

// File: rtl/grr_out_if.sv
// Output channel of the group reversal block: valid, ready and one reordered value with its last flag.
// Depends on grr_pkg for the data width.
interface grr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [grr_pkg::DATA_W-1:0] value_out;
  logic                             last_out;

  modport source (output valid, value_out, last_out, input ready);
  modport sink (input valid, value_out, last_out, output ready);
endinterface

// File: rtl/grr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the banked group store.
module grr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/grr_front.sv
// Front end: accepts values, writes them into the current bank and closes groups.
// Depends on grr_pkg and grr_in_if; hands group descriptors to the queue.
module grr_front (
  input  logic                       clk,
  input  logic                       rst,
  grr_in_if.sink                     in_stream,
  input  logic                       cfg_we,
  input  logic [grr_pkg::GS_W-1:0]   cfg_wdata,
  input  grr_pkg::release_t          rel,
  output grr_pkg::ram_wr_t           ram_wr,
  output logic                       push,
  output grr_pkg::desc_t             push_desc
);

  logic [grr_pkg::GS_W-1:0]      group_size;
  logic [grr_pkg::IDX_W-1:0]     fill;
  logic [grr_pkg::BANK_W-1:0]    wr_bank;
  logic [grr_pkg::NUM_BANKS-1:0] busy;
  logic [grr_pkg::NUM_BANKS-1:0] busy_next;
  logic [grr_pkg::CNT_W-1:0]     k;
  logic [grr_pkg::CNT_W-1:0]     n;
  logic                          accept;
  logic                          hit;
  logic                          close;

  assign in_stream.ready = !busy[wr_bank];
  assign accept = in_stream.valid && in_stream.ready;
  assign k      = grr_pkg::eff_size(group_size);
  assign n      = grr_pkg::CNT_W'(fill) + grr_pkg::CNT_W'(1);
  assign hit    = n >= k;
  assign close  = hit || in_stream.end_of_sequence;

  assign ram_wr.en   = accept;
  assign ram_wr.addr = {wr_bank, fill};
  assign ram_wr.data = in_stream.value_in;

  assign push            = accept && close;
  assign push_desc.bank  = wr_bank;
  assign push_desc.count = n;
  assign push_desc.rev   = hit;
  assign push_desc.last  = in_stream.end_of_sequence;

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= grr_pkg::GS_W'(1);
      fill       <= '0;
      wr_bank    <= '0;
      busy       <= '0;
    end else begin
      busy <= busy_next;
      if (cfg_we) begin
        group_size <= cfg_wdata;
      end
      if (accept) begin
        if (close) begin
          fill    <= '0;
          wr_bank <= wr_bank + grr_pkg::BANK_W'(1);
        end else begin
          fill <= n[grr_pkg::IDX_W-1:0];
        end
      end
    end
  end

endmodule

// File: rtl/grr_queue.sv
// Short descriptor queue between the front end and the drain.
// Depends on grr_pkg for the descriptor type and depth.
module grr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  grr_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           head_valid,
  output grr_pkg::desc_t head
);

  grr_pkg::desc_t              entries [grr_pkg::NUM_BANKS];
  logic [grr_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [grr_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [grr_pkg::Q_PTR_W:0]   count;

  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + grr_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + grr_pkg::Q_PTR_W'(1);
      end
      count <= count + (grr_pkg::Q_PTR_W+1)'(push) - (grr_pkg::Q_PTR_W+1)'(pop);
    end
  end

endmodule

// File: rtl/grr_back.sv
// Drain: reads each queued group from its bank, forward or reversed, into a two-entry output.
// Depends on grr_pkg and grr_out_if; releases banks back to the front end.
module grr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             head_valid,
  input  grr_pkg::desc_t                   head,
  output logic                             pop,
  output grr_pkg::release_t                rel,
  output logic                             ram_re,
  output logic [grr_pkg::ADDR_W-1:0]       ram_raddr,
  input  logic signed [grr_pkg::DATA_W-1:0] ram_rdata,
  grr_out_if.source                        out_stream
);

  logic [grr_pkg::IDX_W-1:0]        idx;
  logic [grr_pkg::CNT_W-1:0]        rev_pos;
  logic [grr_pkg::IDX_W-1:0]        rd_index;
  logic                             last_idx;
  logic                             issue;
  logic                             out_pop;
  logic                             main_free;
  logic [2:0]                       occupancy;
  logic                             pend;
  logic                             pend_last;
  logic                             skid_valid;
  logic signed [grr_pkg::DATA_W-1:0] skid_value;
  logic                             skid_last;

  assign last_idx  = grr_pkg::CNT_W'(idx) == head.count - grr_pkg::CNT_W'(1);
  assign rev_pos   = head.count - grr_pkg::CNT_W'(1) - grr_pkg::CNT_W'(idx);
  assign rd_index  = head.rev ? rev_pos[grr_pkg::IDX_W-1:0] : idx;
  assign out_pop   = out_stream.valid && out_stream.ready;
  assign main_free = !out_stream.valid || out_pop;
  assign occupancy = 3'(out_stream.valid) + 3'(skid_valid) + 3'(pend);
  assign issue     = head_valid && (occupancy <= 3'd1 + 3'(out_pop));

  assign ram_re    = issue;
  assign ram_raddr = {head.bank, rd_index};
  assign pop       = issue && last_idx;
  assign rel.valid = issue && last_idx;
  assign rel.bank  = head.bank;

  always_ff @(posedge clk) begin
    if (pend) begin
      if (main_free) begin
        if (skid_valid) begin
          skid_value <= ram_rdata;
          skid_last  <= pend_last;
        end
      end else begin
        skid_value <= ram_rdata;
        skid_last  <= pend_last;
      end
    end
    if (main_free) begin
      if (skid_valid) begin
        out_stream.value_out <= skid_value;
        out_stream.last_out  <= skid_last;
      end else begin
        out_stream.value_out <= ram_rdata;
        out_stream.last_out  <= pend_last;
      end
    end
    if (issue) begin
      pend_last <= head.last && last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx              <= '0;
      pend             <= 1'b0;
      out_stream.valid <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      pend <= issue;
      if (issue) begin
        idx <= last_idx ? '0 : idx + grr_pkg::IDX_W'(1);
      end
      if (main_free) begin
        if (skid_valid) begin
          out_stream.valid <= 1'b1;
          skid_valid       <= pend;
        end else begin
          out_stream.valid <= pend;
        end
      end else if (pend) begin
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/group_reversal_reorder.sv
// A closed group passes the descriptor queue; its values are read from the group store
// into the output register. Throughput: one value per cycle in and out unless input or
// output stalls; set by the single read port of the two-bank group store.
// The front end stalls only while both banks still wait to be drained.
// Reset is synchronous: it empties the queue and output, and sets the group size to 1.
// The group store is not cleared; only entries written in the current group are read.
module group_reversal_reorder (
  input  logic                     clk,
  input  logic                     rst,
  grr_in_if.sink                   in_stream,
  grr_out_if.source                out_stream,
  input  logic                     cfg_we,
  input  logic [grr_pkg::GS_W-1:0] cfg_wdata
);

  grr_pkg::ram_wr_t            ram_wr;
  grr_pkg::release_t           rel;
  grr_pkg::desc_t              push_desc;
  grr_pkg::desc_t              head;
  logic                        push;
  logic                        pop;
  logic                        head_valid;
  logic                        ram_re;
  logic [grr_pkg::ADDR_W-1:0]  ram_raddr;
  logic [grr_pkg::DATA_W-1:0]  ram_rdata;

  grr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_stream),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rel       (rel),
    .ram_wr    (ram_wr),
    .push      (push),
    .push_desc (push_desc)
  );

  grr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  grr_ram #(
    .WIDTH (grr_pkg::DATA_W),
    .DEPTH (grr_pkg::RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  grr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rel        (rel),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_stream (out_stream)
  );

endmodule

// File: rtl/grr_checker.sv
// Port-level checks of the group reversal block, bound to its top level.
// Depends on grr_pkg and the assertion macros header.
`include "group_reversal_reorder_macros.svh"

module grr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [grr_pkg::DATA_W-1:0] value_out,
  input logic                             last_out
);

  logic                      in_acc;
  logic                      out_acc;
  logic [grr_pkg::BAL_W-1:0] balance;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      balance <= '0;
    end else begin
      balance <= balance + grr_pkg::BAL_W'(in_acc) - grr_pkg::BAL_W'(out_acc);
    end
  end

  `GRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `GRR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(value_out) && $stable(last_out))
  `GRR_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid)
  `GRR_ASSERT_SAME(a_no_invented, out_acc, balance != '0)

endmodule

bind group_reversal_reorder grr_checker u_grr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_stream.valid),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .value_out (out_stream.value_out),
  .last_out  (out_stream.last_out)
);

// File: bench/tb_top.sv
// Self-checking bench for group_reversal_reorder: a group-reversal predictor checks every word.
// Depends on grr_pkg and the grr_in_if and grr_out_if interfaces of the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_WORDS = 470;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic signed [grr_pkg::DATA_W-1:0] value;
    logic                              last;
  } word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [grr_pkg::GS_W-1:0] cfg_wdata;

  grr_in_if  in_bus();
  grr_out_if out_bus();

  group_reversal_reorder i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_bus),
    .out_stream (out_bus),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  logic signed [grr_pkg::DATA_W-1:0] held_words [grr_pkg::MAX_GROUP];
  int                                held_count;
  logic [grr_pkg::GS_W-1:0]          size_reg;
  word_t                             due_words [$];

  bit              steady;
  int              failures;
  int              words_sent;
  int              words_checked;
  int              sequences_sent;
  int              cycle_count;
  logic [grr_pkg::MAX_GROUP:0] sizes_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic void predict_reorder(input logic signed [grr_pkg::DATA_W-1:0] value,
                                          input logic eos);
    int    k;
    int    n;
    word_t w;
    k = (size_reg == 0) ? 1 : ((size_reg > grr_pkg::MAX_GROUP) ? grr_pkg::MAX_GROUP
                                                                : int'(size_reg));
    if (held_count >= grr_pkg::MAX_GROUP) held_count = grr_pkg::MAX_GROUP - 1;
    held_words[held_count] = value;
    held_count++;
    n = held_count;
    if (n < k && !eos) return;
    for (int i = 0; i < n; i++) begin
      w.value = (n >= k) ? held_words[n - 1 - i] : held_words[i];
      w.last  = eos && (i == n - 1);
      due_words.push_back(w);
    end
    held_count = 0;
  endfunction

  function automatic logic signed [grr_pkg::DATA_W-1:0] rand_value();
    logic signed [grr_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = {1'b1, {(grr_pkg::DATA_W-1){1'b0}}};
      1: v = {1'b0, {(grr_pkg::DATA_W-1){1'b1}}};
      2: v = '0;
      3: v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_word(input logic signed [grr_pkg::DATA_W-1:0] value, input logic eos);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.value_in        <= value;
    in_bus.end_of_sequence <= eos;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    predict_reorder(value, eos);
    words_sent++;
    if (eos) sequences_sent++;
  endtask

  task automatic send_sequence(input int len, input bit terminate);
    for (int i = 0; i < len; i++) begin
      send_word(rand_value(), terminate && (i == len - 1));
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_group_size(input logic [grr_pkg::GS_W-1:0] size);
    drain_and_settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    size_reg  = size;
    sizes_seen[size] = 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Output side: outside steady mode, ready may be withdrawn for a random number of cycles before each word.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (out_bus.valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_port
    word_t want;
    if (!rst && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (due_words.size() == 0) begin
        $error("value_out: no word expected, got %0d (last_out %b)",
               out_bus.value_out, out_bus.last_out);
        failures++;
      end else begin
        want = due_words.pop_front();
        if (out_bus.value_out !== want.value) begin
          $error("value_out mismatch: expected %0d, actual %0d", want.value, out_bus.value_out);
          failures++;
        end
        if (out_bus.last_out !== want.last) begin
          $error("last_out mismatch: expected %b, actual %b", want.last, out_bus.last_out);
          failures++;
        end
        words_checked++;
      end
    end
  end

  task automatic test_passthrough();
    send_word({1'b1, {(grr_pkg::DATA_W-1){1'b0}}}, 1'b0);
    send_word({1'b0, {(grr_pkg::DATA_W-1){1'b1}}}, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b1);
  endtask

  task automatic test_group_boundaries();
    set_group_size(5'd4);
    send_sequence(8, 1'b1);
    set_group_size(5'd3);
    send_sequence(5, 1'b1);
    send_sequence(1, 1'b1);
  endtask

  task automatic test_resize_mid_group();
    set_group_size(5'd8);
    send_sequence(3, 1'b0);
    set_group_size(5'd4);
    send_word(rand_value(), 1'b0);
    set_group_size(5'd6);
    send_sequence(2, 1'b0);
    set_group_size(5'd2);
    send_word(rand_value(), 1'b1);
  endtask

  task automatic test_random_sequences();
    int phase;
    int phase_words;
    int k;
    int len;
    phase = 0;
    while (words_sent < TARGET_WORDS) begin
      case (phase)
        0: k = grr_pkg::MAX_GROUP;
        1: k = 1;
        2: k = 2;
        default: k = $urandom_range(1, grr_pkg::MAX_GROUP);
      endcase
      steady = (phase % 3 == 2);
      set_group_size(k[grr_pkg::GS_W-1:0]);
      phase_words = 0;
      while (phase_words < 45) begin
        case ($urandom_range(0, 3))
          0: len = k * $urandom_range(1, 3);
          1: len = 1;
          default: len = $urandom_range(1, 3 * k);
        endcase
        send_sequence(len, 1'b1);
        phase_words += len;
      end
      if (k > 1 && $urandom_range(0, 2) == 0) begin
        send_sequence($urandom_range(1, k - 1), 1'b0);
      end
      phase++;
    end
    steady = 1'b0;
    if (held_count > 0) send_word(rand_value(), 1'b1);
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_wdata              = 5'd1;
    in_bus.valid           = 1'b0;
    in_bus.value_in        = '0;
    in_bus.end_of_sequence = 1'b0;
    size_reg               = 5'd1;
    held_count             = 0;
    steady                 = 1'b0;
    failures               = 0;
    words_sent             = 0;
    words_checked          = 0;
    sequences_sent         = 0;
    cycle_count            = 0;
    sizes_seen             = '0;
    sizes_seen[1]          = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_passthrough();
    test_group_boundaries();
    test_resize_mid_group();
    test_random_sequences();

    drain_and_settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d words in %0d sequences with %0d distinct group sizes.",
             words_sent, sequences_sent, $countones(sizes_seen));
    $display("Checked %0d reordered words, including resizes in the middle of a group.",
             words_checked);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/grr_pkg.sv
rtl/grr_in_if.sv
rtl/grr_out_if.sv
rtl/grr_ram.sv
rtl/grr_front.sv
rtl/grr_queue.sv
rtl/grr_back.sv
rtl/group_reversal_reorder.sv
rtl/grr_checker.sv
bench/tb_top.sv
